>>> rtl/tpq_pkg.sv
package tpq_pkg;

  localparam int unsigned IdWidth = 16;
  localparam int unsigned LevelWidth = 2;

  // function codes on func
  localparam logic [1:0] FUNC_ENQ      = 2'd0;
  localparam logic [1:0] FUNC_DEQ      = 2'd1;
  localparam logic [1:0] FUNC_DEQ_TOP  = 2'd2;
  localparam logic [1:0] FUNC_NOP      = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_EMPTY      = 2'd1;
  localparam logic [1:0] ST_NOT_TOP    = 2'd2;
  localparam logic [1:0] ST_FULL       = 2'd3;

  localparam logic [LevelWidth-1:0] LEVEL_TOP = 2'd1;

  // what every cell does in a cycle
  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_PUSH = 2'd1,
    OP_POP  = 2'd2
  } tpq_op_e;

  typedef struct packed {
    logic                  valid;
    logic [LevelWidth-1:0] level;
    logic [IdWidth-1:0]    id;
  } tpq_cell_t;

  // broadcast from the controller to the row of cells
  typedef struct packed {
    tpq_op_e               op;
    logic [LevelWidth-1:0] level;
    logic [IdWidth-1:0]    id;
  } tpq_ctrl_t;

endpackage

>>> rtl/tpq_cell.sv
module tpq_cell
  import tpq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  tpq_ctrl_t ctrl,
  input  tpq_cell_t prev_cell,
  input  tpq_cell_t next_cell,
  output tpq_cell_t entry
);

  tpq_cell_t entry_next;
  logic      prev_after;
  logic      own_after;

  // prev ranks behind the new word: everything from here on moves one place back
  assign prev_after = prev_cell.valid && (prev_cell.level > ctrl.level);
  assign own_after  = !entry.valid || (entry.level > ctrl.level);

  always_comb begin
    entry_next = entry;
    case (ctrl.op)
      OP_PUSH: begin
        if (prev_after) begin
          entry_next = prev_cell;
        end else if (prev_cell.valid && own_after) begin
          entry_next.valid = 1'b1;
          entry_next.level = ctrl.level;
          entry_next.id    = ctrl.id;
        end
      end
      OP_POP: begin
        entry_next = next_cell;
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry.level <= entry_next.level;
    entry.id    <= entry_next.id;
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      entry.valid <= entry_next.valid;
    end
  end

endmodule

>>> rtl/three_level_priority_queue.sv
// channel  | handshake             | payload
// ---------+-----------------------+-------------------------------------------------
// command  | start, busy           | func, priority_req, item_id
// result   | done (one-cycle strobe)| out_valid, out_id, out_priority, waiting_count,
//          |                       | is_empty, status
//
// one command word a cycle while busy is low: a word accepted at one edge gives
// its result word, marked by done, in the next cycle; the cells update in that edge
// busy is high during reset and for the cycle after reset is released, then low
// synchronous reset empties every cell; no clearing pass is needed
// the receiver cannot stall, so a result word is shown for exactly one cycle
module three_level_priority_queue
  import tpq_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
)(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            func,
  input  logic [LevelWidth-1:0] priority_req,
  input  logic [IdWidth-1:0]    item_id,
  output logic                  done,
  output logic                  out_valid,
  output logic [IdWidth-1:0]    out_id,
  output logic [LevelWidth-1:0] out_priority,
  output logic [4:0]            waiting_count,
  output logic                  is_empty,
  output logic [1:0]            status
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // the row of cells holds the words sorted by level, oldest first within a
  // level; valid cells always form an unbroken run from cell 0
  tpq_cell_t            cells    [CAPACITY];
  tpq_cell_t            prev_in  [CAPACITY];
  tpq_cell_t            next_in  [CAPACITY];
  logic [CAPACITY-1:0]  valid_vec;
  tpq_ctrl_t            ctrl;

  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;
  logic                  accept;
  logic                  out_valid_next;
  logic [IdWidth-1:0]    out_id_next;
  logic [LevelWidth-1:0] out_priority_next;
  logic [1:0]            status_next;
  logic [LevelWidth-1:0] enq_level;

  assign accept = start && !busy;

  // a request for level zero counts as the top level
  assign enq_level = (priority_req == '0) ? LEVEL_TOP : priority_req;

  // command decode: push into the row, pop the head, or leave it alone
  always_comb begin
    ctrl.op           = OP_HOLD;
    ctrl.level        = enq_level;
    ctrl.id           = item_id;
    count_next        = count;
    out_valid_next    = 1'b0;
    out_id_next       = '0;
    out_priority_next = '0;
    status_next       = ST_OK;
    if (accept) begin
      unique case (func)
        FUNC_ENQ: begin
          if (count >= CW'(CAPACITY)) begin
            status_next = ST_FULL;
          end else begin
            ctrl.op    = OP_PUSH;
            count_next = count + 1'b1;
          end
        end
        FUNC_DEQ, FUNC_DEQ_TOP: begin
          if (count == '0) begin
            status_next = ST_EMPTY;
          end else if (func == FUNC_DEQ_TOP && cells[0].level != LEVEL_TOP) begin
            status_next = ST_NOT_TOP;
          end else begin
            ctrl.op           = OP_POP;
            count_next        = count - 1'b1;
            out_valid_next    = 1'b1;
            out_id_next       = cells[0].id;
            out_priority_next = cells[0].level;
          end
        end
        FUNC_NOP: begin
          status_next = ST_OK;
        end
        default: begin
          status_next = ST_OK;
        end
      endcase
    end
  end

  // neighbour wiring: cell 0 sees a top-ranked sentinel before it, the last
  // cell sees an empty word behind it
  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_row
      if (gi == 0) begin : g_first
        assign prev_in[gi] = '{valid: 1'b1, level: '0, id: '0};
      end else begin : g_mid_prev
        assign prev_in[gi] = cells[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign next_in[gi] = '{valid: 1'b0, level: '0, id: '0};
      end else begin : g_mid_next
        assign next_in[gi] = cells[gi+1];
      end

      tpq_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .prev_cell (prev_in[gi]),
        .next_cell (next_in[gi]),
        .entry     (cells[gi])
      );

      assign valid_vec[gi] = cells[gi].valid;
    end
  endgenerate

  // stored count and result word registers
  always_ff @(posedge clk) begin
    out_valid     <= out_valid_next;
    out_id        <= out_id_next;
    out_priority  <= out_priority_next;
    waiting_count <= 5'(count_next);
    is_empty      <= (count_next == '0);
    status        <= status_next;
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
      busy  <= 1'b1;
    end else begin
      count <= count_next;
      done  <= accept;
      busy  <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  // valid cells form an unbroken run from the head
  a_contiguous: assert property (@(posedge clk) disable iff (rst)
    ((valid_vec >> 1) & ~valid_vec) == '0)
    else $error("gap in the row of cells");

  // the counter tracks the occupied cells
  a_count: assert property (@(posedge clk) disable iff (rst)
    count == CW'($countones(valid_vec)))
    else $error("count disagrees with occupied cells");

  // a result word only follows an accepted command word
  a_done: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept))
    else $error("result without a command");

  // a returned word always carries ok status and a real level
  a_out_ok: assert property (@(posedge clk) disable iff (rst)
    (done && out_valid) |-> (status == ST_OK && out_priority != '0))
    else $error("returned word with bad status or level");

  // a full drop leaves the count unchanged
  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    (accept && func == FUNC_ENQ && count >= CW'(CAPACITY)) |=> $stable(count))
    else $error("dropped word changed the count");
`endif

endmodule
